// ===== rtl/core/pic_pkg.sv =====
// Shared constants and register index codes for the point-in-cylinder test block.
`default_nettype none

package pic_pkg;

   localparam int COORD_WIDTH_DEFAULT = 16;
   localparam int CSR_INDEX_WIDTH     = 3;

   // Reset value of top_z and of the radius: 1.0 in Q8.8.
   localparam int RESET_ONE = 256;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_BOTTOM_X   = 3'd0,
      CSR_BOTTOM_Y   = 3'd1,
      CSR_BOTTOM_Z   = 3'd2,
      CSR_TOP_X      = 3'd3,
      CSR_TOP_Y      = 3'd4,
      CSR_TOP_Z      = 3'd5,
      CSR_CYL_RADIUS = 3'd6
   } csr_index_type;

endpackage

`default_nettype wire

// ===== rtl/core/point_in_cylinder_test_top.sv =====
// Pipelined point-in-finite-cylinder test: config registers, datapath and checks.
`default_nettype none

// Tests each streamed 3D point against a finite cylinder held in CSRs (bottom
// center, top center, radius). With axis A = top - bottom and T = point -
// bottom, a point is inside when 0 <= A.T <= |A|^2 and |A x T|^2 <= r^2|A|^2;
// the surface counts as inside and a zero-length axis reports outside for all
// points. Exact integer math, no division. The datapath is an 8-stage
// pipeline: difference, products, sums, magnitudes, half-width partial
// squares, square assembly, final sums, compare-and-output. One point enters
// per cycle unless every stage is full and the response side is stalled.
// The term r^2|A|^2 is formed as (r*Ax)^2 + (r*Ay)^2 + (r*Az)^2 in three
// squaring lanes built like the cross-product lanes. Each stage has its own
// valid bit and holds while it is full and the stage after it cannot move
// on, so bubbles are squeezed out and the block keeps taking points while
// a finished result waits. CSRs are written through a separate
// channel that is always ready; write them only when no point is in flight.
// Indexes beyond the radius register are dropped.
module point_in_cylinder_test_top #(
   parameter int COORD_WIDTH = pic_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // config write channel
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pic_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [COORD_WIDTH-1:0]              csr_wdata,
   // point request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [COORD_WIDTH-1:0]       req_point_x,
   input  logic signed [COORD_WIDTH-1:0]       req_point_y,
   input  logic signed [COORD_WIDTH-1:0]       req_point_z,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_is_inside
);
   import pic_pkg::*;

   localparam int W     = COORD_WIDTH;
   localparam int D     = W + 1;      // coordinate difference, signed
   localparam int P     = 2 * D;      // product of two differences, signed
   localparam int C     = P + 1;      // cross component, signed
   localparam int M     = P;          // magnitude fed to the squarers
   localparam int H     = M / 2;      // half of a magnitude
   localparam int HW    = P + 2;      // dot product and axis length, signed
   localparam int Q     = 2 * M;      // one square
   localparam int S     = Q + 2;      // sum of three squares
   localparam int NSTG  = 8;
   localparam int NLANE = 6;          // 0..2 cross, 3..5 radius times axis

   localparam logic [W-1:0]   TOP_Z_RST  = W'(RESET_ONE);
   localparam logic [W-2:0]   RADIUS_RST = (W-1)'(RESET_ONE);

   // ---------------------------------------------------------------------------
   // CSRs
   // ---------------------------------------------------------------------------
   logic signed [W-1:0] bottom_x_ff, bottom_y_ff, bottom_z_ff;
   logic signed [W-1:0] top_x_ff, top_y_ff, top_z_ff;
   logic [W-2:0]        cyl_radius_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         bottom_x_ff   <= '0;
         bottom_y_ff   <= '0;
         bottom_z_ff   <= '0;
         top_x_ff      <= '0;
         top_y_ff      <= '0;
         top_z_ff      <= TOP_Z_RST;
         cyl_radius_ff <= RADIUS_RST;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_BOTTOM_X:   bottom_x_ff   <= csr_wdata;
            CSR_BOTTOM_Y:   bottom_y_ff   <= csr_wdata;
            CSR_BOTTOM_Z:   bottom_z_ff   <= csr_wdata;
            CSR_TOP_X:      top_x_ff      <= csr_wdata;
            CSR_TOP_Y:      top_y_ff      <= csr_wdata;
            CSR_TOP_Z:      top_z_ff      <= csr_wdata;
            CSR_CYL_RADIUS: cyl_radius_ff <= csr_wdata[W-2:0];
            default: ;
         endcase
      end
   end

   logic signed [W-1:0] rad_s;
   assign rad_s = signed'({1'b0, cyl_radius_ff});

   // ---------------------------------------------------------------------------
   // Flow control: a stage loads when it is empty or its content moves on.
   // ---------------------------------------------------------------------------
   logic [NSTG-1:0] vld_ff, vld_in, adv;

   always_comb begin
      adv[NSTG-1] = !vld_ff[NSTG-1] || rsp_ready;
      for (int k = NSTG - 2; k >= 0; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
   end

   always_comb begin
      vld_in[0] = adv[0] ? req_valid : vld_ff[0];
      for (int k = 1; k < NSTG; k++) begin
         vld_in[k] = adv[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_ready = adv[0];
   assign rsp_valid = vld_ff[NSTG-1];

   // ---------------------------------------------------------------------------
   // Stage 1: axis and point offsets from the bottom center.
   // ---------------------------------------------------------------------------
   logic signed [D-1:0] a_s1_in [3];
   logic signed [D-1:0] t_s1_in [3];
   logic signed [D-1:0] a_s1_ff [3];
   logic signed [D-1:0] t_s1_ff [3];

   always_comb begin
      a_s1_in[0] = D'(top_x_ff) - D'(bottom_x_ff);
      a_s1_in[1] = D'(top_y_ff) - D'(bottom_y_ff);
      a_s1_in[2] = D'(top_z_ff) - D'(bottom_z_ff);
      t_s1_in[0] = D'(req_point_x) - D'(bottom_x_ff);
      t_s1_in[1] = D'(req_point_y) - D'(bottom_y_ff);
      t_s1_in[2] = D'(req_point_z) - D'(bottom_z_ff);
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         a_s1_ff <= a_s1_in;
         t_s1_ff <= t_s1_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 2: all products. Cross terms in pairs: x uses ay*tz - az*ty, etc.
   // ---------------------------------------------------------------------------
   logic signed [P-1:0] dot_s2_in [3];
   logic signed [P-1:0] len_s2_in [3];
   logic signed [P-1:0] ra_s2_in  [3];
   logic signed [P-1:0] crs_s2_in [6];
   logic signed [P-1:0] dot_s2_ff [3];
   logic signed [P-1:0] len_s2_ff [3];
   logic signed [P-1:0] ra_s2_ff  [3];
   logic signed [P-1:0] crs_s2_ff [6];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dot_s2_in[i] = P'(a_s1_ff[i]) * P'(t_s1_ff[i]);
         len_s2_in[i] = P'(a_s1_ff[i]) * P'(a_s1_ff[i]);
         ra_s2_in[i]  = P'(rad_s) * P'(a_s1_ff[i]);
      end
      crs_s2_in[0] = P'(a_s1_ff[1]) * P'(t_s1_ff[2]);
      crs_s2_in[1] = P'(a_s1_ff[2]) * P'(t_s1_ff[1]);
      crs_s2_in[2] = P'(a_s1_ff[2]) * P'(t_s1_ff[0]);
      crs_s2_in[3] = P'(a_s1_ff[0]) * P'(t_s1_ff[2]);
      crs_s2_in[4] = P'(a_s1_ff[0]) * P'(t_s1_ff[1]);
      crs_s2_in[5] = P'(a_s1_ff[1]) * P'(t_s1_ff[0]);
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         dot_s2_ff <= dot_s2_in;
         len_s2_ff <= len_s2_in;
         ra_s2_ff  <= ra_s2_in;
         crs_s2_ff <= crs_s2_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 3: dot product A.T, axis length |A|^2, cross components.
   // ---------------------------------------------------------------------------
   logic signed [HW-1:0] h_s3_in, len_s3_in, h_s3_ff, len_s3_ff;
   logic signed [C-1:0]  val_s3_in [NLANE];
   logic signed [C-1:0]  val_s3_ff [NLANE];

   always_comb begin
      h_s3_in   = HW'(dot_s2_ff[0]) + HW'(dot_s2_ff[1]) + HW'(dot_s2_ff[2]);
      len_s3_in = HW'(len_s2_ff[0]) + HW'(len_s2_ff[1]) + HW'(len_s2_ff[2]);
      for (int i = 0; i < 3; i++) begin
         val_s3_in[i]     = C'(crs_s2_ff[2*i]) - C'(crs_s2_ff[2*i+1]);
         val_s3_in[i + 3] = C'(ra_s2_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         h_s3_ff   <= h_s3_in;
         len_s3_ff <= len_s3_in;
         val_s3_ff <= val_s3_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 4: range check along the axis, magnitudes for the squarers.
   // ---------------------------------------------------------------------------
   logic                rng_s4_in, rng_s4_ff;
   logic signed [C-1:0] neg_s4 [NLANE];
   logic [M-1:0]        mag_s4_in [NLANE];
   logic [M-1:0]        mag_s4_ff [NLANE];

   always_comb begin
      rng_s4_in = (len_s3_ff != '0) && !h_s3_ff[HW-1] && (h_s3_ff <= len_s3_ff);
      for (int i = 0; i < NLANE; i++) begin
         neg_s4[i]    = -val_s3_ff[i];
         mag_s4_in[i] = val_s3_ff[i][C-1] ? neg_s4[i][M-1:0] : val_s3_ff[i][M-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         rng_s4_ff <= rng_s4_in;
         mag_s4_ff <= mag_s4_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 5: half-width partial products of each square.
   // ---------------------------------------------------------------------------
   logic         rng_s5_ff;
   logic [M-1:0] hh_s5_in [NLANE];
   logic [M-1:0] hl_s5_in [NLANE];
   logic [M-1:0] ll_s5_in [NLANE];
   logic [M-1:0] hh_s5_ff [NLANE];
   logic [M-1:0] hl_s5_ff [NLANE];
   logic [M-1:0] ll_s5_ff [NLANE];

   always_comb begin
      for (int i = 0; i < NLANE; i++) begin
         hh_s5_in[i] = M'(mag_s4_ff[i][M-1:H]) * M'(mag_s4_ff[i][M-1:H]);
         hl_s5_in[i] = M'(mag_s4_ff[i][M-1:H]) * M'(mag_s4_ff[i][H-1:0]);
         ll_s5_in[i] = M'(mag_s4_ff[i][H-1:0]) * M'(mag_s4_ff[i][H-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         rng_s5_ff <= rng_s4_ff;
         hh_s5_ff  <= hh_s5_in;
         hl_s5_ff  <= hl_s5_in;
         ll_s5_ff  <= ll_s5_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 6: assemble each square: hh*2^2H + 2*hl*2^H + ll.
   // ---------------------------------------------------------------------------
   logic         rng_s6_ff;
   logic [Q-1:0] sq_s6_in [NLANE];
   logic [Q-1:0] sq_s6_ff [NLANE];

   always_comb begin
      for (int i = 0; i < NLANE; i++) begin
         sq_s6_in[i] = (Q'(hh_s5_ff[i]) << (2 * H)) + (Q'(hl_s5_ff[i]) << (H + 1))
                     + Q'(ll_s5_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv[5]) begin
         rng_s6_ff <= rng_s5_ff;
         sq_s6_ff  <= sq_s6_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 7: |A x T|^2 and r^2 |A|^2.
   // ---------------------------------------------------------------------------
   logic         rng_s7_ff;
   logic [S-1:0] area_s7_in, limit_s7_in, area_s7_ff, limit_s7_ff;

   always_comb begin
      area_s7_in  = S'(sq_s6_ff[0]) + S'(sq_s6_ff[1]) + S'(sq_s6_ff[2]);
      limit_s7_in = S'(sq_s6_ff[3]) + S'(sq_s6_ff[4]) + S'(sq_s6_ff[5]);
   end

   always_ff @(posedge clock) begin
      if (adv[6]) begin
         rng_s7_ff   <= rng_s6_ff;
         area_s7_ff  <= area_s7_in;
         limit_s7_ff <= limit_s7_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 8: output register. Surface counts as inside.
   // ---------------------------------------------------------------------------
   logic rsp_is_inside_in, rsp_is_inside_ff;

   assign rsp_is_inside_in = rng_s7_ff && (limit_s7_ff >= area_s7_ff);

   always_ff @(posedge clock) begin
      if (adv[7]) begin
         rsp_is_inside_ff <= rsp_is_inside_in;
      end
   end

   assign rsp_is_inside = rsp_is_inside_ff;

   // ---------------------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------------------
   // Occupancy grows by one for a request beat without a response beat.
   a_occ_grow : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !(rsp_valid && rsp_ready))
      |=> ($countones(vld_ff) == $past($countones(vld_ff)) + 1))
      else $error("pipeline occupancy lost a request beat");

   // Occupancy shrinks by one for a response beat without a request beat.
   a_occ_drop : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !(req_valid && req_ready))
      |=> ($countones(vld_ff) + 1 == $past($countones(vld_ff))))
      else $error("pipeline occupancy out of step with response beats");

   // A full pipeline with a stalled output must not take another point.
   a_full_stall : assert property (@(posedge clock) disable iff (reset)
      ((&vld_ff) && !rsp_ready) |-> !req_ready)
      else $error("request taken while pipeline full and stalled");

   // Reset empties every stage.
   a_reset_empty : assert property (@(posedge clock)
      $past(reset) |-> (vld_ff == '0))
      else $error("stage valid bits not cleared by reset");

endmodule

`default_nettype wire
